// ===== sv/fxalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared opcodes, status codes and the pipeline token type of the fixed-point
// ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_DIV    = 4'd3;
   localparam logic [3:0] OP_GT     = 4'd4;
   localparam logic [3:0] OP_GE     = 4'd5;
   localparam logic [3:0] OP_LT     = 4'd6;
   localparam logic [3:0] OP_LE     = 4'd7;
   localparam logic [3:0] OP_EQ     = 4'd8;
   localparam logic [3:0] OP_NE     = 4'd9;
   localparam logic [3:0] OP_MIN    = 4'd10;
   localparam logic [3:0] OP_MAX    = 4'd11;
   localparam logic [3:0] OP_INC    = 4'd12;
   localparam logic [3:0] OP_DEC    = 4'd13;
   localparam logic [3:0] OP_TO_INT = 4'd14;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   // Control that travels with an item down the divider chain.
   typedef struct packed {
      logic       vld;
      logic       div;
      logic       neg;
      logic       dz;
      logic [1:0] st;
      logic       cmp;
   } fxalu_ctl_type;

endpackage

// ===== sv/fxalu_div_cell.sv =====
// ----------------------------------------------------------------------------
// fxalu_div_cell
// One restoring-division step: shift in a dividend bit, compare against the
// divisor, subtract, append a quotient bit. Registered; moves each cycle that adv is high.
// ----------------------------------------------------------------------------
module fxalu_div_cell
   import fxalu_pkg::*;
#(
   parameter int DW = 32,
   parameter int NW = 40,
   parameter int BIT_IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  fxalu_ctl_type ctl_i,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   input  logic [NW-1:0] num_i,
   input  logic [NW-1:0] quo_i,
   input  logic [DW-1:0] res_i,
   output fxalu_ctl_type ctl_o,
   output logic [DW-1:0] rem_o,
   output logic [DW-1:0] den_o,
   output logic [NW-1:0] num_o,
   output logic [NW-1:0] quo_o,
   output logic [DW-1:0] res_o
);

   fxalu_ctl_type ctl_ff;
   logic [DW-1:0] rem_ff, rem_in, den_ff, res_ff;
   logic [NW-1:0] num_ff, quo_ff, quo_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   // trial remainder and subtract
   always_comb begin
      trial  = {rem_i, num_i[BIT_IDX]};
      diff   = trial - {1'b0, den_i};
      quo_in = quo_i << 1;
      if (!diff[DW]) begin
         rem_in    = diff[DW-1:0];
         quo_in[0] = 1'b1;
      end else begin
         rem_in = trial[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         num_ff <= num_i;
         quo_ff <= quo_in;
         res_ff <= res_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign num_o = num_ff;
   assign quo_o = quo_ff;
   assign res_o = res_ff;

endmodule

// ===== sv/fxalu_front.sv =====
// ----------------------------------------------------------------------------
// fxalu_front
// First stage: simple operations, the multiplier and divide setup.
// ----------------------------------------------------------------------------
module fxalu_front
   import fxalu_pkg::*;
#(
   parameter int DW = 32,
   parameter int FB = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            vld_i,
   input  logic [3:0]      op_i,
   input  logic [DW-1:0]   a_i,
   input  logic [DW-1:0]   b_i,
   output fxalu_ctl_type   ctl_o,
   output logic [DW-1:0]   res_o,
   output logic [DW-1:0]   den_o,
   output logic [DW+FB-1:0] num_o,
   output logic [2*DW-1:0] prod_o,
   output logic            mul_o
);

   localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINR = {1'b1, {(DW-1){1'b0}}};

   logic          sa, sb, lt, gt, eq;
   logic [DW-1:0] ma, mb, t, r;
   logic [DW:0]   ti;
   logic [1:0]    st;
   logic          cmp;
   fxalu_ctl_type ctl_ff, ctl_in;
   logic [DW-1:0] res_ff, den_ff;
   logic [DW+FB-1:0] num_ff;
   logic [2*DW-1:0]  prod_ff;
   logic          mul_ff;

   assign sa = a_i[DW-1];
   assign sb = b_i[DW-1];
   assign ma = sa ? (~a_i + 1'b1) : a_i;
   assign mb = sb ? (~b_i + 1'b1) : b_i;
   assign lt = $signed(a_i) < $signed(b_i);
   assign gt = $signed(b_i) < $signed(a_i);
   assign eq = a_i == b_i;

   // simple operations
   always_comb begin
      r   = '0;
      st  = ST_OK;
      cmp = 1'b0;
      t   = '0;
      ti  = '0;
      unique case (op_i)
         OP_ADD: begin
            t = a_i + b_i;
            r = t;
            if (sa == sb && t[DW-1] != sa) begin
               st = ST_OVF;
               r  = sa ? MINR : MAXP;
            end
         end
         OP_SUB: begin
            t = a_i - b_i;
            r = t;
            if (sa != sb && t[DW-1] != sa) begin
               st = ST_OVF;
               r  = sa ? MINR : MAXP;
            end
         end
         OP_GT:  cmp = gt;
         OP_GE:  cmp = gt | eq;
         OP_LT:  cmp = lt;
         OP_LE:  cmp = lt | eq;
         OP_EQ:  cmp = eq;
         OP_NE:  cmp = !eq;
         OP_MIN: r = lt ? a_i : b_i;
         OP_MAX: r = gt ? a_i : b_i;
         OP_INC: begin
            if (a_i == MAXP) begin
               st = ST_OVF;
               r  = MAXP;
            end else begin
               r = a_i + 1'b1;
            end
         end
         OP_DEC: begin
            if (a_i == MINR) begin
               st = ST_OVF;
               r  = MINR;
            end else begin
               r = a_i - 1'b1;
            end
         end
         OP_TO_INT: begin
            ti = ({1'b0, ma} + ((DW+1)'(1) << (FB-1))) >> FB;
            t  = ti[DW-1:0];
            r  = sa ? (~t + 1'b1) : t;
         end
         default: r = '0;
      endcase
   end

   always_comb begin
      ctl_in     = '0;
      ctl_in.vld = vld_i;
      ctl_in.div = (op_i == OP_DIV);
      ctl_in.neg = sa ^ sb;
      ctl_in.dz  = (op_i == OP_DIV) && (b_i == '0);
      ctl_in.st  = st;
      ctl_in.cmp = cmp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff  <= r;
         den_ff  <= mb;
         num_ff  <= {ma, {FB{1'b0}}};
         prod_ff <= ma * mb;
         mul_ff  <= (op_i == OP_MUL);
      end
   end

   assign ctl_o  = ctl_ff;
   assign res_o  = res_ff;
   assign den_o  = den_ff;
   assign num_o  = num_ff;
   assign prod_o = prod_ff;
   assign mul_o  = mul_ff;

endmodule

// ===== sv/fixed_point_alu_q24_8_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core
// Signed fixed-point ALU with a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries opcode, a_raw, b_raw.
//   Response channel (rsp_valid/rsp_ready) returns result_raw, cmp_true and
//   status, one response per request, in order.
//   Every operation travels the same pipe: one front stage (simple ops,
//   the multiplier and divide setup), DATA_WIDTH+FRAC_BITS divider cells
//   of one quotient bit each, then combinational rounding into an output
//   register.
//   The pipe holds DATA_WIDTH+FRAC_BITS+2 register stages: the front
//   stage, the divider cells and the output register.
//   Throughput is one transfer per cycle unless the receiver stalls; the
//   divider cell chain sets the latency, the multiplier and each cell set
//   the clock period. Reset clears all valid bits; no items are in flight
//   afterward. When the receiver stalls, the whole pipe holds; req_ready
//   drops only when the output register is full and not being taken.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_core
   import fxalu_pkg::*;
#(
   parameter int FRAC_BITS  = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [3:0]            req_opcode,
   input  logic [DATA_WIDTH-1:0] req_a_raw,
   input  logic [DATA_WIDTH-1:0] req_b_raw,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_result_raw,
   output logic                  rsp_cmp_true,
   output logic [1:0]            rsp_status
);

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int NW = DW + FB;
   localparam int NC = NW;
   localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINR = {1'b1, {(DW-1){1'b0}}};

   logic adv;

   fxalu_ctl_type   f_ctl;
   logic [DW-1:0]   f_res, f_den;
   logic [NW-1:0]   f_num;
   logic [2*DW-1:0] f_prod;
   logic            f_mul;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   fxalu_front #(.DW(DW), .FB(FB)) u_front (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .vld_i  (req_valid),
      .op_i   (req_opcode),
      .a_i    (req_a_raw),
      .b_i    (req_b_raw),
      .ctl_o  (f_ctl),
      .res_o  (f_res),
      .den_o  (f_den),
      .num_o  (f_num),
      .prod_o (f_prod),
      .mul_o  (f_mul)
   );

   // multiply rounding and saturation, result enters the chain as res
   logic [2*DW:0]   prnd;
   logic [2*DW-FB:0] pq;
   logic [DW-1:0]   mres;
   logic [1:0]      mst;
   fxalu_ctl_type   c0_ctl;
   logic [DW-1:0]   c0_res;

   always_comb begin
      prnd = {1'b0, f_prod} + ((2*DW+1)'(1) << (FB-1));
      pq   = prnd[2*DW:FB];
      mst  = ST_OK;
      if (!f_ctl.neg) begin
         if (pq > (2*DW-FB+1)'(MAXP)) begin
            mst = ST_OVF; mres = MAXP;
         end else begin
            mres = pq[DW-1:0];
         end
      end else begin
         if (pq > (2*DW-FB+1)'(MINR)) begin
            mst = ST_OVF; mres = MINR;
         end else begin
            mres = ~pq[DW-1:0] + 1'b1;
         end
      end
      c0_ctl = f_ctl;
      c0_res = f_res;
      if (f_mul) begin
         c0_res    = mres;
         c0_ctl.st = mst;
      end
   end

   // divider cell chain
   fxalu_ctl_type ch_ctl [NC+1];
   logic [DW-1:0] ch_rem [NC+1];
   logic [DW-1:0] ch_den [NC+1];
   logic [NW-1:0] ch_num [NC+1];
   logic [NW-1:0] ch_quo [NC+1];
   logic [DW-1:0] ch_res [NC+1];

   assign ch_ctl[0] = c0_ctl;
   assign ch_rem[0] = '0;
   assign ch_den[0] = f_den;
   assign ch_num[0] = f_num;
   assign ch_quo[0] = '0;
   assign ch_res[0] = c0_res;

   for (genvar g = 0; g < NC; g++) begin : g_cell
      fxalu_div_cell #(.DW(DW), .NW(NW), .BIT_IDX(NW-1-g)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .ctl_i (ch_ctl[g]),
         .rem_i (ch_rem[g]),
         .den_i (ch_den[g]),
         .num_i (ch_num[g]),
         .quo_i (ch_quo[g]),
         .res_i (ch_res[g]),
         .ctl_o (ch_ctl[g+1]),
         .rem_o (ch_rem[g+1]),
         .den_o (ch_den[g+1]),
         .num_o (ch_num[g+1]),
         .quo_o (ch_quo[g+1]),
         .res_o (ch_res[g+1])
      );
   end

   // divide rounding and saturation, final select
   fxalu_ctl_type e_ctl;
   logic [DW:0]   rem2;
   logic          rup;
   logic [NW:0]   qr;
   logic [DW-1:0] dres, fres;
   logic [1:0]    dst, fst;

   always_comb begin
      e_ctl = ch_ctl[NC];
      rem2  = {ch_rem[NC], 1'b0};
      rup   = rem2 >= {1'b0, ch_den[NC]};
      qr    = {1'b0, ch_quo[NC]} + (NW+1)'(rup);
      dst   = ST_OK;
      if (!e_ctl.neg) begin
         if (qr > (NW+1)'(MAXP)) begin
            dst = ST_OVF; dres = MAXP;
         end else begin
            dres = qr[DW-1:0];
         end
      end else begin
         if (qr > (NW+1)'(MINR)) begin
            dst = ST_OVF; dres = MINR;
         end else begin
            dres = ~qr[DW-1:0] + 1'b1;
         end
      end
      fres = ch_res[NC];
      fst  = e_ctl.st;
      if (e_ctl.div) begin
         if (e_ctl.dz) begin
            fres = '0; fst = ST_DIV0;
         end else begin
            fres = dres; fst = dst;
         end
      end
   end

   // output register
   logic          vld_ff;
   logic [DW-1:0] res_ff;
   logic          cmp_ff;
   logic [1:0]    st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= e_ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= fres;
         cmp_ff <= e_ctl.cmp;
         st_ff  <= fst;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_result_raw = res_ff;
   assign rsp_cmp_true   = cmp_ff;
   assign rsp_status     = st_ff;

endmodule

// ===== sv/fxalu_checker.sv =====
// ----------------------------------------------------------------------------
// fxalu_checker
// Port-level checks of the fixed-point ALU.
// ----------------------------------------------------------------------------
module fxalu_checker
   import fxalu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_cmp_true,
   input logic [1:0]  rsp_status
);

   // ready follows the output register
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready mismatch");

   // a stalled response stays valid with its status unchanged
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

   // status code is legal
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");

   // a true comparison result never carries a flagged status
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmp_true |-> rsp_status == ST_OK)
      else $error("comparison with status");

endmodule

bind fixed_point_alu_q24_8_core fxalu_checker u_fxalu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_cmp_true (rsp_cmp_true),
   .rsp_status   (rsp_status)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the Q24.8 fixed-point ALU. Each request is predicted in exact integer
// arithmetic, and the predictions are queued in order. The checker compares
// every response with the oldest prediction, field by field. Directed corner
// cases run first, then random traffic with bursty requests and a stalling
// receiver. One long receiver hold-off fills the pipe.
// ----------------------------------------------------------------------------
module tb_top;
   import fxalu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 8;
   localparam int DW   = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int OP_NONE = 15;

   typedef struct packed {
      logic [31:0] res;
      logic        cmp;
      logic [1:0]  st;
   } alu_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [3:0]    req_opcode = '0;
   logic [DW-1:0] req_a_raw = '0;
   logic [DW-1:0] req_b_raw = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [DW-1:0] rsp_result_raw;
   logic          rsp_cmp_true;
   logic [1:0]    rsp_status;

   alu_result_type pending_results[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          hold_rsp = 1'b0;

   fixed_point_alu_q24_8_core dut (.*);

   always #10 clock = ~clock;

   // Saturate a signed 80-bit value to 32 bits.
   function automatic logic [31:0] sat32(input logic signed [79:0] v, inout logic [1:0] st);
      if (v > 80'sh7fffffff) begin
         st = ST_OVF;
         return 32'h7fffffff;
      end
      if (v < -80'sh80000000) begin
         st = ST_OVF;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // Expected ALU response for one request.
   function automatic alu_result_type alu_predict(input logic [3:0] op,
                                                  input logic [31:0] a,
                                                  input logic [31:0] b);
      alu_result_type r;
      logic signed [79:0] sa, sb, acc;
      logic [79:0] ma, mb, q, rm;
      logic neg;
      sa = signed'(a);
      sb = signed'(b);
      ma = sa < 0 ? -sa : sa;
      mb = sb < 0 ? -sb : sb;
      neg = a[31] ^ b[31];
      r = '0;
      case (op)
         OP_ADD: r.res = sat32(sa + sb, r.st);
         OP_SUB: r.res = sat32(sa - sb, r.st);
         OP_MUL: begin
            q = (ma * mb + (80'd1 << (FRAC - 1))) >> FRAC;
            acc = neg ? -signed'(q) : signed'(q);
            r.res = sat32(acc, r.st);
         end
         OP_DIV: begin
            if (mb == 0) begin
               r.st = ST_DIV0;
            end else begin
               q = (ma << FRAC) / mb;
               rm = (ma << FRAC) % mb;
               if (rm >= mb - rm) q = q + 1;
               acc = neg ? -signed'(q) : signed'(q);
               r.res = sat32(acc, r.st);
            end
         end
         OP_GT: r.cmp = sa > sb;
         OP_GE: r.cmp = sa >= sb;
         OP_LT: r.cmp = sa < sb;
         OP_LE: r.cmp = sa <= sb;
         OP_EQ: r.cmp = sa == sb;
         OP_NE: r.cmp = sa != sb;
         OP_MIN: r.res = sa < sb ? a : b;
         OP_MAX: r.res = sa > sb ? a : b;
         OP_INC: r.res = sat32(sa + 1, r.st);
         OP_DEC: r.res = sat32(sa - 1, r.st);
         OP_TO_INT: begin
            q = (ma + (80'd1 << (FRAC - 1))) >> FRAC;
            acc = a[31] ? -signed'(q) : signed'(q);
            r.res = acc[31:0];
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // Send one request; waits for its transfer. Leaves valid high.
   task automatic send_op(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_a_raw  <= a;
      req_b_raw  <= b;
      pending_results.push_back(alu_predict(op, a, b));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Occasional random gap between bursts; most requests get none.
   task automatic sender_gap();
      int n;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 1) ? $urandom_range(0, 1023) : -$urandom_range(0, 1023);
         3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
         4: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] corner[6];
      corner = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h100, 32'hffffff80};
      for (int op = 0; op <= OP_NONE; op++)
         send_op(4'(op), corner[op % 6], corner[(op + 1) % 6]);
      send_op(OP_DIV, 32'h100, 32'h0);
      send_op(OP_MUL, 32'h80000000, 32'h80000000);
      send_op(OP_INC, 32'h7fffffff, 32'h0);
      send_op(OP_DEC, 32'h80000000, 32'h0);
      send_op(OP_TO_INT, 32'hffffff80, 32'h0);
      send_op(OP_TO_INT, 32'h80, 32'hffffffff);
      send_op(OP_MUL, 32'h80, 32'h1);
      send_op(OP_DIV, 32'h1, 32'h200);
      send_op(OP_EQ, 32'h5a5a5a5a, 32'h5a5a5a5a);
      req_valid <= 1'b0;
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_op(4'($urandom_range(0, 15)), rand_operand(), rand_operand());
         sender_gap();
      end
      req_valid <= 1'b0;
   endtask

   // Receiver holds off while requests keep flowing, filling the pipe.
   task automatic test_backpressure();
      hold_rsp <= 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         test_random(120);
      join
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 63) < 48) || ($urandom_range(0, 1) == 0);
   end

   // Response checker.
   always @(posedge clock) begin
      alu_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, rsp_result_raw);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_result_raw !== exp_r.res) begin
               $display("%0t: result_raw expected %h actual %h", $realtime, exp_r.res,
                        rsp_result_raw);
               error_count++;
            end
            if (rsp_cmp_true !== exp_r.cmp) begin
               $display("%0t: cmp_true expected %b actual %b", $realtime, exp_r.cmp,
                        rsp_cmp_true);
               error_count++;
            end
            if (rsp_status !== exp_r.st) begin
               $display("%0t: status expected %0d actual %0d", $realtime, exp_r.st,
                        rsp_status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int drain;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(900);
      drain = 0;
      while (pending_results.size() != 0 && drain < WATCHDOG_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
